/* rtl/core/mjvs_pkg.sv */
// Shared types and constants for the multi-joint velocity servo core.
// Standalone package: no dependencies. Used by multi_joint_velocity_servo_core.
package mjvs_pkg;

    // Number of joints the 4-bit joint field can address
    localparam int JOINT_SPAN = 16;

    // Item function codes
    localparam logic [2:0] FUNC_TARGET    = 3'd0;
    localparam logic [2:0] FUNC_FEEDFWD   = 3'd1;
    localparam logic [2:0] FUNC_REFERENCE = 3'd2;
    localparam logic [2:0] FUNC_GAIN      = 3'd3;
    localparam logic [2:0] FUNC_LIMIT     = 3'd4;
    localparam logic [2:0] FUNC_SAMPLE    = 3'd5;
    localparam logic [2:0] FUNC_HALT      = 3'd6;
    localparam logic [2:0] FUNC_GO        = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] REG_VOID_LIMIT    = 2'd0;
    localparam logic [1:0] REG_GAIN_CEILING  = 2'd1;
    localparam logic [1:0] REG_SPEED_CEILING = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  VOID_LIMIT_RESET    = 8'd5;
    localparam logic [19:0] GAIN_CEILING_RESET  = 20'd655360;
    localparam logic [23:0] SPEED_CEILING_RESET = 24'd6553600;

    // Input word
    typedef struct packed {
        logic [2:0]         func;
        logic [3:0]         joint;
        logic signed [31:0] value;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [3:0]         joint_out;
        logic signed [31:0] velocity;
        logic               send_enable;
    } out_word_t;

endpackage

/* rtl/core/multi_joint_velocity_servo_core.sv */
// Multi-joint velocity servo: per-joint P control with feedforward and clamp.
// Depends on mjvs_pkg for word types, function codes and register indexes.
//
//  channel  | signals                          | direction | word
//  ---------+----------------------------------+-----------+-----------------
//  input    | in_valid, in_ready, in_data      | in        | mjvs_pkg::in_word_t
//  result   | out_valid, out_ready, out_data   | out       | mjvs_pkg::out_word_t
//  config   | cfg_we, cfg_index, cfg_data      | in        | 24-bit write data
//
// A sample steps through accept (error subtract), two passes of the shared
// 33x11 multiplier over the low and high gain halves, then scale and clamp.
// Halt and go walk NUM_JOINTS joints (capped at 16), copying encoder readings
// into targets one joint per cycle. Other words complete on accept.
// Reset clears the tables and control registers at once; no clearing pass is needed.
// A result waiting in the output register stalls only the final clamp stage.
module multi_joint_velocity_servo_core #(
    parameter int NUM_JOINTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mjvs_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mjvs_pkg::out_word_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    localparam int DEPTH = (NUM_JOINTS < mjvs_pkg::JOINT_SPAN) ? NUM_JOINTS
                                                              : mjvs_pkg::JOINT_SPAN;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_MLO  = 2'd2;
    localparam logic [1:0] ST_MHI  = 2'd3;
    localparam logic [1:0] ST_FIN  = 2'd3 ^ 2'd3;

    // Per-joint tables
    logic signed [31:0] target_reg  [DEPTH];
    logic signed [31:0] feedfwd_reg [DEPTH];
    logic        [19:0] gain_reg    [DEPTH];
    logic        [23:0] limit_reg   [DEPTH];
    logic signed [31:0] encoder_reg [DEPTH];

    // Configuration
    logic [7:0]  void_limit_reg;
    logic [19:0] gain_ceiling_reg;
    logic [23:0] speed_ceiling_reg;

    // Control state
    logic [2:0]  state_reg, state_next;
    logic [7:0]  idle_reg, idle_next;
    logic        fast_reg, fast_next;
    logic        started_reg, started_next;
    logic        suspended_reg, suspended_next;
    logic [IW-1:0] walk_reg, walk_next;
    logic        out_valid_reg, out_valid_next;

    // Item datapath
    logic [IW-1:0]      jidx_reg;
    logic [3:0]         joint_reg;
    logic signed [32:0] err_reg;
    logic signed [53:0] acc_reg, acc_next;
    mjvs_pkg::out_word_t out_reg;

    // Decode
    logic          acc_in;
    logic          in_rng;
    logic [IW-1:0] in_idx;
    logic          is_sample;
    logic          is_halt_go;
    logic          open_period;
    logic [7:0]    idle_inc;
    logic          clear_ff;
    logic          fin_go;

    // Shared multiplier
    logic signed [10:0] mul_b;
    logic signed [43:0] prod;

    // Final scale and clamp
    logic signed [37:0] scaled;
    logic signed [38:0] vsum;
    logic signed [38:0] vlim;
    logic signed [31:0] vel;

    assign in_ready  = (state_reg[1:0] == ST_IDLE) && !state_reg[2];
    assign acc_in    = in_valid && in_ready;
    assign in_rng    = ({28'd0, in_data.joint} < 32'(NUM_JOINTS));
    assign in_idx    = in_data.joint[IW-1:0];
    assign is_sample = (in_data.func == mjvs_pkg::FUNC_SAMPLE) && in_rng;
    assign is_halt_go = (in_data.func == mjvs_pkg::FUNC_HALT)
                     || (in_data.func == mjvs_pkg::FUNC_GO);
    assign open_period = acc_in && is_sample && (in_data.joint == 4'd0);
    assign idle_inc  = (idle_reg == 8'hFF) ? idle_reg : idle_reg + 8'd1;
    assign clear_ff  = (open_period && !fast_reg && (idle_inc > void_limit_reg))
                    || (acc_in && is_halt_go);
    assign fin_go    = (state_reg == {1'b1, ST_FIN}) && (!out_valid_reg || out_ready);

    // Multiply the error by one 10-bit gain half per pass
    assign mul_b = (state_reg == {1'b0, ST_MLO}) ? $signed({1'b0, gain_reg[jidx_reg][9:0]})
                                                 : $signed({1'b0, gain_reg[jidx_reg][19:10]});
    assign prod  = err_reg * mul_b;

    // Accumulate partial products
    always_comb
    begin
        acc_next = acc_reg;
        if (state_reg == {1'b0, ST_MLO})
        begin
            acc_next = 54'(prod);
        end
        else if (state_reg == {1'b0, ST_MHI})
        begin
            acc_next = acc_reg + (54'(prod) <<< 10);
        end
    end

    // Drop fraction bits (floor), add feedforward, clamp to the joint limit, zero while halted
    always_comb
    begin
        scaled = 38'(acc_reg >>> 16);
        vsum   = 39'(scaled) + 39'(feedfwd_reg[jidx_reg]);
        if (vsum > $signed({15'd0, limit_reg[jidx_reg]}))
        begin
            vlim = $signed({15'd0, limit_reg[jidx_reg]});
        end
        else if (vsum < -$signed({15'd0, limit_reg[jidx_reg]}))
        begin
            vlim = -$signed({15'd0, limit_reg[jidx_reg]});
        end
        else
        begin
            vlim = vsum;
        end
        vel = suspended_reg ? 32'sd0 : vlim[31:0];
    end

    // Sequencer and control flags
    always_comb
    begin
        state_next     = state_reg;
        walk_next      = walk_reg;
        idle_next      = idle_reg;
        fast_next      = fast_reg;
        started_next   = started_reg;
        suspended_next = suspended_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            {1'b0, ST_IDLE}:
            begin
                if (acc_in)
                begin
                    if (is_halt_go)
                    begin
                        suspended_next = (in_data.func == mjvs_pkg::FUNC_HALT);
                        walk_next      = '0;
                        state_next     = {1'b0, ST_WALK};
                    end
                    else if (in_rng)
                    begin
                        case (in_data.func)
                            mjvs_pkg::FUNC_TARGET, mjvs_pkg::FUNC_FEEDFWD:
                            begin
                                fast_next    = 1'b1;
                                started_next = 1'b1;
                            end
                            mjvs_pkg::FUNC_REFERENCE:
                            begin
                                started_next = 1'b1;
                            end
                            mjvs_pkg::FUNC_SAMPLE:
                            begin
                                state_next = {1'b0, ST_MLO};
                                if (in_data.joint == 4'd0)
                                begin
                                    idle_next = fast_reg ? 8'd0 : idle_inc;
                                    fast_next = 1'b0;
                                end
                            end
                            default:
                            begin
                                state_next = state_reg;
                            end
                        endcase
                    end
                end
            end
            {1'b0, ST_WALK}:
            begin
                walk_next = walk_reg + 1'b1;
                if (walk_reg == IW'(DEPTH - 1))
                begin
                    state_next = {1'b0, ST_IDLE};
                end
            end
            {1'b0, ST_MLO}:
            begin
                state_next = {1'b0, ST_MHI};
            end
            {1'b0, ST_MHI}:
            begin
                state_next = {1'b1, ST_FIN};
            end
            {1'b1, ST_FIN}:
            begin
                if (fin_go)
                begin
                    out_valid_next = 1'b1;
                    state_next     = {1'b0, ST_IDLE};
                end
            end
            default:
            begin
                state_next = {1'b0, ST_IDLE};
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= {1'b0, ST_IDLE};
            walk_reg      <= '0;
            idle_reg      <= '0;
            fast_reg      <= 1'b0;
            started_reg   <= 1'b0;
            suspended_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            idle_reg      <= idle_next;
            fast_reg      <= fast_next;
            started_reg   <= started_next;
            suspended_reg <= suspended_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            void_limit_reg    <= mjvs_pkg::VOID_LIMIT_RESET;
            gain_ceiling_reg  <= mjvs_pkg::GAIN_CEILING_RESET;
            speed_ceiling_reg <= mjvs_pkg::SPEED_CEILING_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mjvs_pkg::REG_VOID_LIMIT:    void_limit_reg    <= cfg_data[7:0];
                mjvs_pkg::REG_GAIN_CEILING:  gain_ceiling_reg  <= cfg_data[19:0];
                mjvs_pkg::REG_SPEED_CEILING: speed_ceiling_reg <= cfg_data;
                default:                     void_limit_reg    <= void_limit_reg;
            endcase
        end
    end

    // Joint tables: direct writes on accept, target copy during the walk, feedforward clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                target_reg[k]  <= '0;
                feedfwd_reg[k] <= '0;
                gain_reg[k]    <= '0;
                limit_reg[k]   <= '0;
                encoder_reg[k] <= '0;
            end
        end
        else
        begin
            if (clear_ff)
            begin
                for (int k = 0; k < DEPTH; k++)
                begin
                    feedfwd_reg[k] <= '0;
                end
            end
            if (state_reg == {1'b0, ST_WALK})
            begin
                target_reg[walk_reg] <= encoder_reg[walk_reg];
            end
            if (acc_in && in_rng)
            begin
                case (in_data.func)
                    mjvs_pkg::FUNC_TARGET:
                    begin
                        target_reg[in_idx] <= in_data.value;
                    end
                    mjvs_pkg::FUNC_FEEDFWD:
                    begin
                        feedfwd_reg[in_idx] <= in_data.value;
                    end
                    mjvs_pkg::FUNC_REFERENCE:
                    begin
                        target_reg[in_idx]  <= in_data.value;
                        feedfwd_reg[in_idx] <= '0;
                    end
                    mjvs_pkg::FUNC_GAIN:
                    begin
                        // Reject negative gain, clamp to the ceiling
                        if (!in_data.value[31])
                        begin
                            if (in_data.value > $signed({12'd0, gain_ceiling_reg}))
                            begin
                                gain_reg[in_idx] <= gain_ceiling_reg;
                            end
                            else
                            begin
                                gain_reg[in_idx] <= in_data.value[19:0];
                            end
                        end
                    end
                    mjvs_pkg::FUNC_LIMIT:
                    begin
                        // Accept only a limit strictly between zero and the ceiling
                        if ((in_data.value > 32'sd0)
                            && (in_data.value < $signed({8'd0, speed_ceiling_reg})))
                        begin
                            limit_reg[in_idx] <= in_data.value[23:0];
                        end
                    end
                    mjvs_pkg::FUNC_SAMPLE:
                    begin
                        encoder_reg[in_idx] <= in_data.value;
                    end
                    default:
                    begin
                        encoder_reg[in_idx] <= encoder_reg[in_idx];
                    end
                endcase
            end
        end
    end

    // Item datapath: error on accept, accumulate, result word on finish
    always_ff @(posedge clk)
    begin
        if (acc_in && is_sample)
        begin
            jidx_reg  <= in_idx;
            joint_reg <= in_data.joint;
            err_reg   <= {target_reg[in_idx][31], target_reg[in_idx]}
                       - {in_data.value[31], in_data.value};
        end
        acc_reg <= acc_next;
        if (fin_go)
        begin
            out_reg.joint_out   <= joint_reg;
            out_reg.velocity    <= vel;
            out_reg.send_enable <= started_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* tb/multi_joint_velocity_servo_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for multi_joint_velocity_servo_core: random and directed servo words.
// Depends on mjvs_pkg for word types, function codes and register indexes, and on the core.
module multi_joint_velocity_servo_core_tb;

    localparam int     SETTLE_CYCLES = 48;
    localparam int     MAX_REPORTS   = 60;
    localparam longint S32_MAX       = 64'sd2147483647;
    localparam longint S32_MIN       = -64'sd2147483648;

    logic                clk       = 1'b0;
    logic                rst_n;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    mjvs_pkg::in_word_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    mjvs_pkg::out_word_t out_data;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [23:0]         cfg_data;

    // Word queues and run bookkeeping
    mjvs_pkg::in_word_t  pending_words[$];
    mjvs_pkg::out_word_t velocity_cmds_due[$];
    mjvs_pkg::out_word_t cmd_due;
    bit        gaps_on;
    bit        stalls_on;
    bit        gen_halted;
    int        gap_left;
    int        stall_left;
    int        words_queued;
    int        words_driven;
    int        words_sent;
    int        cmds_checked;
    int        settings_used;
    int        fail_count;

    // Servo shadow: per-joint tables, period tracking and register copies
    logic signed [31:0] target_pos[mjvs_pkg::JOINT_SPAN]  = '{default: '0};
    logic signed [31:0] feedfwd_vel[mjvs_pkg::JOINT_SPAN] = '{default: '0};
    logic signed [31:0] encoder_pos[mjvs_pkg::JOINT_SPAN] = '{default: '0};
    logic [19:0]        p_gain[mjvs_pkg::JOINT_SPAN]      = '{default: '0};
    logic [23:0]        speed_lim[mjvs_pkg::JOINT_SPAN]   = '{default: '0};
    int                 quiet_periods;
    bit                 setpoint_fresh;
    bit                 drive_armed;
    bit                 halted;
    logic [7:0]         quiet_allow;
    logic [19:0]        gain_cap;
    logic [23:0]        speed_cap;

    multi_joint_velocity_servo_core #(
        .NUM_JOINTS (mjvs_pkg::JOINT_SPAN)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Hard stop for a hung run
    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    // Mostly no wait, often a short one, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Pick a value suited to the function, with extremes and rejected cases mixed in
    function automatic logic signed [31:0] draw_value(logic [2:0] f);
        int unsigned r;
        int unsigned spread;
        r      = $urandom_range(0, 11);
        spread = (f == mjvs_pkg::FUNC_FEEDFWD) ? (1 << 18) : (1 << 20);
        if (f == mjvs_pkg::FUNC_GAIN)
        begin
            if (r == 0)
                return $urandom | 32'h8000_0000;
            if (r == 1)
                return $urandom;
            return $urandom_range(0, gain_cap + gain_cap / 4 + 1);
        end
        if (f == mjvs_pkg::FUNC_LIMIT)
        begin
            if (r == 0)
                return $urandom;
            if (r == 1)
                return 32'(speed_cap);
            if (r == 2)
                return 32'(speed_cap) - 32'd1;
            return $urandom_range(0, speed_cap + speed_cap / 8 + 1);
        end
        case (r)
            0:       return $urandom;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh8000_0000;
            3:       return -32'sd1;
            4:       return 32'sd0;
            default: return $urandom_range(0, 2 * spread) - spread;
        endcase
    endfunction

    // Advance the servo shadow by one accepted word and queue any command it yields
    task automatic track_servo_word(mjvs_pkg::in_word_t w);
        int                  j;
        int                  k;
        logic signed [31:0]  val;
        logic [31:0]         gain_req;
        longint              err;
        longint              vel;
        longint              lim;
        mjvs_pkg::out_word_t cmd;
        j   = int'(w.joint);
        val = w.value;
        case (w.func)
            mjvs_pkg::FUNC_HALT, mjvs_pkg::FUNC_GO:
            begin
                halted = (w.func == mjvs_pkg::FUNC_HALT);
                for (k = 0; k < mjvs_pkg::JOINT_SPAN; k++)
                begin
                    target_pos[k]  = encoder_pos[k];
                    feedfwd_vel[k] = '0;
                end
            end
            mjvs_pkg::FUNC_TARGET:
            begin
                target_pos[j]  = val;
                setpoint_fresh = 1'b1;
                drive_armed    = 1'b1;
            end
            mjvs_pkg::FUNC_FEEDFWD:
            begin
                feedfwd_vel[j] = val;
                setpoint_fresh = 1'b1;
                drive_armed    = 1'b1;
            end
            mjvs_pkg::FUNC_REFERENCE:
            begin
                target_pos[j]  = val;
                feedfwd_vel[j] = '0;
                drive_armed    = 1'b1;
            end
            mjvs_pkg::FUNC_GAIN:
            begin
                // negative requests are dropped, large ones clamp to the cap
                if (val >= 0)
                begin
                    gain_req = val;
                    if (gain_req > gain_cap)
                        gain_req = gain_cap;
                    p_gain[j] = gain_req[19:0];
                end
            end
            mjvs_pkg::FUNC_LIMIT:
            begin
                if (val > 0 && $unsigned(val) < speed_cap)
                    speed_lim[j] = val[23:0];
            end
            default:
            begin
                // a joint-0 sample opens a new servo period
                if (j == 0)
                begin
                    if (setpoint_fresh)
                        quiet_periods = 0;
                    else
                    begin
                        if (quiet_periods < 255)
                            quiet_periods++;
                        if (quiet_periods > quiet_allow)
                            for (k = 0; k < mjvs_pkg::JOINT_SPAN; k++)
                                feedfwd_vel[k] = '0;
                    end
                    setpoint_fresh = 1'b0;
                end
                encoder_pos[j] = val;
                err = longint'(target_pos[j]) - longint'(val);
                vel = (longint'(p_gain[j]) * err) >>> 16;
                vel = vel + longint'(feedfwd_vel[j]);
                lim = longint'(speed_lim[j]);
                if (vel > S32_MAX)
                    vel = S32_MAX;
                if (vel < S32_MIN)
                    vel = S32_MIN;
                if (vel > lim)
                    vel = lim;
                if (vel < -lim)
                    vel = -lim;
                if (halted)
                    vel = 0;
                cmd.joint_out   = w.joint;
                cmd.velocity    = vel[31:0];
                cmd.send_enable = drive_armed;
                velocity_cmds_due.push_back(cmd);
            end
        endcase
    endtask

    task automatic note_mismatch(string what, string want, string got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %s, actual %s", $time, what, want, got);
        else if (fail_count == MAX_REPORTS + 1)
            $display("%0t ns: further mismatches counted but not shown", $time);
    endtask

    // Input word driver: hold until taken, then wait out a gap before the next
    always @(negedge clk)
    begin
        if (!in_valid || words_sent == words_driven)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_words.size() > 0)
            begin
                in_data  <= pending_words.pop_front();
                in_valid <= 1'b1;
                words_driven++;
                gap_left = gaps_on ? idle_len() : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = stalls_on ? idle_len() : 0;
        end
    end

    // Monitor: predict on each accepted input word, check each accepted result word
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            track_servo_word(in_data);
            words_sent++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (velocity_cmds_due.size() == 0)
                note_mismatch("command", "none",
                              $sformatf("joint %0d velocity %0d",
                                        out_data.joint_out, out_data.velocity));
            else
            begin
                cmd_due = velocity_cmds_due.pop_front();
                cmds_checked++;
                if (out_data.joint_out !== cmd_due.joint_out)
                    note_mismatch("joint_out", $sformatf("%0d", cmd_due.joint_out),
                                  $sformatf("%0d", out_data.joint_out));
                if (out_data.velocity !== cmd_due.velocity)
                    note_mismatch("velocity", $sformatf("%0d", cmd_due.velocity),
                                  $sformatf("%0d", out_data.velocity));
                if (out_data.send_enable !== cmd_due.send_enable)
                    note_mismatch("send_enable", $sformatf("%b", cmd_due.send_enable),
                                  $sformatf("%b", out_data.send_enable));
            end
        end
    end

    task automatic push_word(logic [2:0] f, logic [3:0] j, logic signed [31:0] v);
        mjvs_pkg::in_word_t w;
        w.func  = f;
        w.joint = j;
        w.value = v;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // One servo period or a noise word: optional halt or go and setpoints, then samples mostly led by joint 0
    task automatic push_period(bit allow_fast);
        int         r;
        int         pick;
        int         n;
        int         k;
        logic [2:0] f;
        r = $urandom_range(0, 99);
        // a noise word on any joint, a random function (fast setpoints, halt and go become samples if barred)
        if (r < 12)
        begin
            f = 3'($urandom_range(0, 7));
            if (!allow_fast && (f == mjvs_pkg::FUNC_TARGET || f == mjvs_pkg::FUNC_FEEDFWD ||
                                f == mjvs_pkg::FUNC_HALT || f == mjvs_pkg::FUNC_GO))
                f = mjvs_pkg::FUNC_SAMPLE;
            if (f == mjvs_pkg::FUNC_HALT || f == mjvs_pkg::FUNC_GO)
                gen_halted = (f == mjvs_pkg::FUNC_HALT);
            push_word(f, 4'($urandom_range(0, 15)), draw_value(f));
            return;
        end
        // leave or enter a halt now and then
        if (allow_fast && gen_halted && r < 40)
        begin
            push_word(mjvs_pkg::FUNC_GO, 4'($urandom_range(0, 15)), $urandom);
            gen_halted = 1'b0;
        end
        else if (allow_fast && !gen_halted && r >= 97)
        begin
            push_word(mjvs_pkg::FUNC_HALT, 4'($urandom_range(0, 15)), $urandom);
            gen_halted = 1'b1;
        end
        if (allow_fast ? (r % 3 != 0) : (r % 5 == 0))
        begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
            begin
                pick = $urandom_range(0, 9);
                if (!allow_fast && pick < 7)
                    pick = 7 + pick % 3;
                f = (pick < 4) ? mjvs_pkg::FUNC_TARGET :
                    (pick < 7) ? mjvs_pkg::FUNC_FEEDFWD :
                    (pick == 7) ? mjvs_pkg::FUNC_REFERENCE :
                    (pick == 8) ? mjvs_pkg::FUNC_GAIN : mjvs_pkg::FUNC_LIMIT;
                push_word(f, 4'($urandom_range(0, 15)), draw_value(f));
            end
        end
        if (!allow_fast || $urandom_range(0, 3) != 0)
            push_word(mjvs_pkg::FUNC_SAMPLE, 4'd0, draw_value(mjvs_pkg::FUNC_SAMPLE));
        n = allow_fast ? $urandom_range(1, 4) : $urandom_range(0, 1);
        for (k = 0; k < n; k++)
            push_word(mjvs_pkg::FUNC_SAMPLE, 4'($urandom_range(1, 15)),
                      draw_value(mjvs_pkg::FUNC_SAMPLE));
    endtask

    // Wait until every word is taken and every command has come, then let the core settle
    task automatic drain_and_settle();
        while (pending_words.size() != 0 || in_valid || velocity_cmds_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            mjvs_pkg::REG_VOID_LIMIT:    quiet_allow = data[7:0];
            mjvs_pkg::REG_GAIN_CEILING:  gain_cap    = data[19:0];
            mjvs_pkg::REG_SPEED_CEILING: speed_cap   = data;
            default:                     ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Reprogram the registers on an idle core, set up every joint, then run periods
    task automatic run_phase(int quiet, int gcap, int scap, bit gaps, bit stalls,
                             bit allow_fast, int n);
        logic [23:0] junk;
        int          k;
        int          goal;
        junk       = 24'($urandom);
        junk[7:0]  = 8'(quiet);
        write_reg(mjvs_pkg::REG_VOID_LIMIT, junk);
        junk       = 24'($urandom);
        junk[19:0] = 20'(gcap);
        write_reg(mjvs_pkg::REG_GAIN_CEILING, junk);
        write_reg(mjvs_pkg::REG_SPEED_CEILING, 24'(scap));
        settings_used++;
        gaps_on   = gaps;
        stalls_on = stalls;
        goal      = words_queued + n;
        if (gen_halted)
        begin
            push_word(mjvs_pkg::FUNC_GO, 4'($urandom_range(0, 15)), $urandom);
            gen_halted = 1'b0;
        end
        for (k = 0; k < mjvs_pkg::JOINT_SPAN; k++)
        begin
            push_word(mjvs_pkg::FUNC_GAIN, 4'(k), draw_value(mjvs_pkg::FUNC_GAIN));
            push_word(mjvs_pkg::FUNC_LIMIT, 4'(k), draw_value(mjvs_pkg::FUNC_LIMIT));
            push_word(mjvs_pkg::FUNC_FEEDFWD, 4'(k), draw_value(mjvs_pkg::FUNC_FEEDFWD));
        end
        while (words_queued < goal)
            push_period(allow_fast);
        drain_and_settle();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet_allow = mjvs_pkg::VOID_LIMIT_RESET;
        gain_cap    = mjvs_pkg::GAIN_CEILING_RESET;
        speed_cap   = mjvs_pkg::SPEED_CEILING_RESET;
        gaps_on     = 1'b1;
        stalls_on   = 1'b1;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Never-limited joint before any setpoint: zero command, send_enable low
        push_word(mjvs_pkg::FUNC_SAMPLE, 4'd3, 32'sh0001_0000);
        // Negative gain dropped, oversize gain clamped to the cap
        push_word(mjvs_pkg::FUNC_GAIN, 4'd1, -32'sd1);
        push_word(mjvs_pkg::FUNC_GAIN, 4'd1, 32'sh7FFF_FFFF);
        // Limits of zero, at the cap and negative are dropped; one below the cap holds
        push_word(mjvs_pkg::FUNC_LIMIT, 4'd1, 32'sd0);
        push_word(mjvs_pkg::FUNC_LIMIT, 4'd1, 32'sd6553600);
        push_word(mjvs_pkg::FUNC_LIMIT, 4'd1, 32'sh8000_0000);
        push_word(mjvs_pkg::FUNC_LIMIT, 4'd1, 32'sd6553599);
        // Full-scale error: saturate, then clamp to the limit
        push_word(mjvs_pkg::FUNC_TARGET, 4'd1, 32'sh7FFF_FFFF);
        push_word(mjvs_pkg::FUNC_SAMPLE, 4'd1, 32'sh8000_0000);
        push_word(mjvs_pkg::FUNC_SAMPLE, 4'd1, 32'sh7FFF_FFFF);
        // Feedforward adds to the proportional term; a reference drops it
        push_word(mjvs_pkg::FUNC_FEEDFWD, 4'd1, 32'sh0005_0000);
        push_word(mjvs_pkg::FUNC_SAMPLE, 4'd1, 32'sh7FFF_FFF0);
        push_word(mjvs_pkg::FUNC_REFERENCE, 4'd1, 32'sh7FFF_FFFF);
        push_word(mjvs_pkg::FUNC_SAMPLE, 4'd1, 32'sh7FFF_0000);
        // Smallest gain and limit on the top joint with a large negative error
        push_word(mjvs_pkg::FUNC_TARGET, 4'd15, 32'sh8000_0000);
        push_word(mjvs_pkg::FUNC_GAIN, 4'd15, 32'sd1);
        push_word(mjvs_pkg::FUNC_LIMIT, 4'd15, 32'sd1);
        push_word(mjvs_pkg::FUNC_SAMPLE, 4'd15, 32'sh7FFF_FFFF);
        // Halt forces zero; go copies encoders into targets
        push_word(mjvs_pkg::FUNC_HALT, 4'd9, 32'sh1234_5678);
        push_word(mjvs_pkg::FUNC_SAMPLE, 4'd1, 32'sd0);
        push_word(mjvs_pkg::FUNC_GO, 4'd0, -32'sd1);
        push_word(mjvs_pkg::FUNC_SAMPLE, 4'd1, 32'sh0002_0000);
        drain_and_settle();

        run_phase(3, 400000, 3000000, 1'b1, 1'b1, 1'b1, 250);
        run_phase(0, 20'hFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, 200);
        // quiet limit at its top: the period count saturates and feedforward survives
        run_phase(255, $urandom_range(65536, 800000), $urandom_range(1 << 16, 1 << 23),
                  1'b1, 1'b0, 1'b0, 700);
        run_phase($urandom_range(1, 20), 0, 0, 1'b0, 1'b1, 1'b1, 100);
        run_phase($urandom_range(1, 8), $urandom_range(0, 20'hFFFFF),
                  $urandom_range(0, 24'hFFFFFF), 1'b0, 1'b0, 1'b1, 250);
        run_phase($urandom_range(0, 255), $urandom_range(0, 20'hFFFFF),
                  $urandom_range(0, 24'hFFFFFF), 1'b1, 1'b1, 1'b1, 300);

        $display("Run took %0d servo words and checked %0d velocity commands", words_sent,
                 cmds_checked);
        $display("across %0d register settings, halts, clamps and quiet-period clears.",
                 settings_used + 1);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
